@@ rtl/core/sync_length_crc_frame_receiver_assert.svh @@
`ifndef SYNC_LENGTH_CRC_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_LENGTH_CRC_FRAME_RECEIVER_ASSERT_SVH

// check cons in the same cycle as ante
`define SLCFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define SLCFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/slcfr_pkg.sv @@
package slcfr_pkg;

  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_CRC_ERR = 2'd2;
  localparam logic [1:0] ST_RESYNC  = 2'd3;

  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [6:0] max_length;
  } slcfr_cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  command;
    logic [6:0]  length;
    logic [31:0] frames_ok;
    logic [31:0] crc_errors;
    logic [31:0] resyncs;
  } slcfr_job_t;

  typedef struct packed {
    logic       we;
    logic [6:0] addr;
    logic [7:0] data;
  } slcfr_mem_wr_t;

endpackage

@@ rtl/core/slcfr_front.sv @@
module slcfr_front #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  slcfr_pkg::slcfr_cfg_t   cfg,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_byte,
  input  logic                    q_full,
  output logic                    q_push,
  output slcfr_pkg::slcfr_job_t   q_job,
  output slcfr_pkg::slcfr_mem_wr_t mem_wr,
  input  logic                    store_done,
  output logic                    store_busy
);
  import slcfr_pkg::*;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [6:0]  DEPTH_LEN = 7'(PAYLOAD_DEPTH);

  typedef enum logic [2:0] {
    PH_SYNC_A, PH_SYNC_B, PH_LEN, PH_CMD, PH_DATA, PH_CRC_LO, PH_CRC_HI
  } phase_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [31:0] ok_r, ok_nxt;
  logic [31:0] err_r, err_nxt;
  logic [31:0] rsy_r, rsy_nxt;
  logic        busy_r, busy_nxt;

  logic        accept;
  logic [6:0]  limit;
  logic [6:0]  pos_inc;
  logic [15:0] crc_upd;

  assign in_tready  = !q_full && !(phase_r == PH_DATA && busy_r);
  assign accept     = in_tvalid && in_tready;
  assign limit      = (cfg.max_length < DEPTH_LEN) ? cfg.max_length : DEPTH_LEN;
  assign pos_inc    = pos_r + 7'd1;
  assign crc_upd    = crc_step((phase_r == PH_LEN) ? CRC_INIT : crc_r, in_byte);
  assign store_busy = busy_r;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    pos_nxt   = pos_r;
    lo_nxt    = lo_r;
    crc_nxt   = crc_r;
    ok_nxt    = ok_r;
    err_nxt   = err_r;
    rsy_nxt   = rsy_r;
    busy_nxt  = busy_r && !store_done;
    q_push    = 1'b0;
    q_job     = '0;
    mem_wr    = '0;
    if (accept) begin
      unique case (phase_r)
        PH_SYNC_A: begin
          if (in_byte == cfg.sync_first) phase_nxt = PH_SYNC_B;
        end
        PH_SYNC_B: begin
          if (in_byte == cfg.sync_second) phase_nxt = PH_LEN;
          else if (in_byte != cfg.sync_first) phase_nxt = PH_SYNC_A;
        end
        PH_LEN: begin
          if (in_byte > {1'b0, limit}) begin
            rsy_nxt   = rsy_r + 32'd1;
            phase_nxt = PH_SYNC_A;
            q_push    = 1'b1;
            q_job.status = ST_RESYNC;
          end else begin
            len_nxt   = in_byte[6:0];
            pos_nxt   = '0;
            crc_nxt   = crc_upd;
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = in_byte;
          crc_nxt   = crc_upd;
          phase_nxt = (len_r == 7'd0) ? PH_CRC_LO : PH_DATA;
        end
        PH_DATA: begin
          mem_wr.we   = 1'b1;
          mem_wr.addr = pos_r;
          mem_wr.data = in_byte;
          crc_nxt     = crc_upd;
          pos_nxt     = pos_inc;
          if (pos_inc >= len_r) phase_nxt = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          lo_nxt    = in_byte;
          phase_nxt = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          q_push        = 1'b1;
          q_job.command = cmd_r;
          q_job.length  = len_r;
          if ({in_byte, lo_r} == crc_r) begin
            ok_nxt = ok_r + 32'd1;
            if (len_r == 7'd0) begin
              q_job.status = ST_EMPTY;
            end else begin
              q_job.status = ST_PAYLOAD;
              busy_nxt     = 1'b1;
            end
          end else begin
            err_nxt      = err_r + 32'd1;
            q_job.status = ST_CRC_ERR;
          end
          phase_nxt = PH_SYNC_A;
        end
        default: phase_nxt = PH_SYNC_A;
      endcase
    end
    if (q_job.status == ST_RESYNC) begin
      q_job.command = '0;
      q_job.length  = '0;
    end
    q_job.frames_ok  = ok_nxt;
    q_job.crc_errors = err_nxt;
    q_job.resyncs    = rsy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC_A;
      len_r   <= '0;
      cmd_r   <= '0;
      pos_r   <= '0;
      lo_r    <= '0;
      crc_r   <= '0;
      ok_r    <= '0;
      err_r   <= '0;
      rsy_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      pos_r   <= pos_nxt;
      lo_r    <= lo_nxt;
      crc_r   <= crc_nxt;
      ok_r    <= ok_nxt;
      err_r   <= err_nxt;
      rsy_r   <= rsy_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

@@ rtl/core/slcfr_queue.sv @@
module slcfr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  slcfr_pkg::slcfr_job_t push_job,
  input  logic                  pop,
  output slcfr_pkg::slcfr_job_t head_job,
  output logic                  full,
  output logic                  empty
);
  import slcfr_pkg::*;

  slcfr_job_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_job = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/slcfr_back.sv @@
module slcfr_back #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  slcfr_pkg::slcfr_mem_wr_t mem_wr,
  input  slcfr_pkg::slcfr_job_t    head_job,
  input  logic                     q_empty,
  output logic                     q_pop,
  output logic                     store_done,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [1:0]               out_status,
  output logic [7:0]               out_command,
  output logic [6:0]               out_length,
  output logic [5:0]               out_index,
  output logic [7:0]               out_payload,
  output logic                     out_last,
  output logic [31:0]              out_frames_ok,
  output logic [31:0]              out_crc_errors,
  output logic [31:0]              out_resyncs
);
  import slcfr_pkg::*;

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_LOAD} state_t;

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] rd_q;

  state_t      state_r, state_nxt;
  slcfr_job_t  job_r, job_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic        vld_r, vld_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [7:0]  pay_r, pay_nxt;
  logic        last_r, last_nxt;
  logic [31:0] ok_r, ok_nxt;
  logic [31:0] err_r, err_nxt;
  logic [31:0] rsy_r, rsy_nxt;

  logic       out_free;
  logic [6:0] pos_inc;
  logic       at_last;

  always_ff @(posedge clk) begin
    if (mem_wr.we) mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
    rd_q <= mem[pos_r[AW-1:0]];
  end

  assign out_free = !vld_r || out_tready;
  assign pos_inc  = pos_r + 7'd1;
  assign at_last  = (pos_inc == job_r.length);

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    pos_nxt    = pos_r;
    vld_nxt    = vld_r && !out_tready;
    st_nxt     = st_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    pay_nxt    = pay_r;
    last_nxt   = last_r;
    ok_nxt     = ok_r;
    err_nxt    = err_r;
    rsy_nxt    = rsy_r;
    q_pop      = 1'b0;
    store_done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (head_job.status == ST_PAYLOAD) begin
            job_nxt   = head_job;
            pos_nxt   = '0;
            state_nxt = S_FETCH;
          end else begin
            vld_nxt  = 1'b1;
            st_nxt   = head_job.status;
            cmd_nxt  = head_job.command;
            len_nxt  = head_job.length;
            idx_nxt  = '0;
            pay_nxt  = '0;
            last_nxt = 1'b1;
            ok_nxt   = head_job.frames_ok;
            err_nxt  = head_job.crc_errors;
            rsy_nxt  = head_job.resyncs;
          end
        end
      end
      S_FETCH: state_nxt = S_LOAD;
      S_LOAD: begin
        if (out_free) begin
          vld_nxt  = 1'b1;
          st_nxt   = ST_PAYLOAD;
          cmd_nxt  = job_r.command;
          len_nxt  = job_r.length;
          idx_nxt  = pos_r[5:0];
          pay_nxt  = rd_q;
          last_nxt = at_last;
          ok_nxt   = job_r.frames_ok;
          err_nxt  = job_r.crc_errors;
          rsy_nxt  = job_r.resyncs;
          pos_nxt  = pos_inc;
          if (at_last) begin
            store_done = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    job_r  <= job_nxt;
    pos_r  <= pos_nxt;
    st_r   <= st_nxt;
    cmd_r  <= cmd_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    pay_r  <= pay_nxt;
    last_r <= last_nxt;
    ok_r   <= ok_nxt;
    err_r  <= err_nxt;
    rsy_r  <= rsy_nxt;
  end

  assign out_tvalid     = vld_r;
  assign out_status     = st_r;
  assign out_command    = cmd_r;
  assign out_length     = len_r;
  assign out_index      = idx_r;
  assign out_payload    = pay_r;
  assign out_last       = last_r;
  assign out_frames_ok  = ok_r;
  assign out_crc_errors = err_r;
  assign out_resyncs    = rsy_r;

endmodule

@@ rtl/core/sync_length_crc_frame_receiver.sv @@
// Result path: a byte that trips the length limit, fails the CRC or closes an empty frame raises
// out_tvalid once its job has passed the job queue and the output register; a good payload frame
// is read out of the store one payload byte per result, each through a fetch and a load state.
// Throughput: one byte per cycle while parsing; input stalls while the two-entry job queue
// is full, and a payload byte of the next frame waits until the back end has read out the store.
// Reset (rst_n low, synchronous): parser to sync hunt, counters and queue cleared,
// registers back to 0xA5, 0x5A and 64; the payload store is not cleared.
`include "sync_length_crc_frame_receiver_assert.svh"

module sync_length_crc_frame_receiver #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [7:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] command, [14:8] length, [20:15] index, [28:21] payload,
  // [60:29] frames_ok_count, [92:61] crc_error_count, [124:93] resync_count, [127:125] zero
  output logic [127:0] out_tdata,
  output logic [1:0]   out_tuser,  // [1:0] status
  output logic         out_tlast
);
  import slcfr_pkg::*;

  slcfr_cfg_t    cfg_r;
  slcfr_job_t    push_job, head_job;
  slcfr_mem_wr_t mem_wr;
  logic          q_push, q_pop, q_full, q_empty;
  logic          store_done, store_busy;
  logic [7:0]    o_command;
  logic [6:0]    o_length;
  logic [5:0]    o_index;
  logic [7:0]    o_payload;
  logic [31:0]   o_ok, o_err, o_rsy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= 8'hA5;
      cfg_r.sync_second <= 8'h5A;
      cfg_r.max_length  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_wdata;
        REG_SYNC_SECOND: cfg_r.sync_second <= cfg_wdata;
        REG_MAX_LENGTH:  cfg_r.max_length  <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  slcfr_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job),
    .mem_wr     (mem_wr),
    .store_done (store_done),
    .store_busy (store_busy)
  );

  slcfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  slcfr_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mem_wr         (mem_wr),
    .head_job       (head_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .store_done     (store_done),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_status     (out_tuser),
    .out_command    (o_command),
    .out_length     (o_length),
    .out_index      (o_index),
    .out_payload    (o_payload),
    .out_last       (out_tlast),
    .out_frames_ok  (o_ok),
    .out_crc_errors (o_err),
    .out_resyncs    (o_rsy)
  );

  assign out_tdata = {3'b000, o_rsy, o_err, o_ok, o_payload, o_index, o_length, o_command};

  `SLCFR_ASSERT_NOW(a_push_not_full, q_push, !q_full, "job pushed into full queue")
  `SLCFR_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "job popped from empty queue")
  `SLCFR_ASSERT_NOW(a_done_when_busy, store_done, store_busy, "read-out done without payload job")
  `SLCFR_ASSERT_NEXT(a_busy_blocks_write, store_busy && !store_done, !mem_wr.we,
    "payload store written during read-out")

endmodule
